// File: hdl/ptc_pkg.sv
// Shared types and constants of the pressure and temperature compensation pipeline.
`default_nettype none
package ptc_pkg;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_calib;

    typedef enum logic [1:0] {
        CFG_CALIB_T  = 2'd0,
        CFG_CALIB_PA = 2'd1,
        CFG_CALIB_PB = 2'd2,
        CFG_CALIB_PC = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [23:0] tcenti;
        logic [23:0] tfine;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [25:0] a;
        logic [19:0] adcp;
    } t_tout;

    typedef struct packed {
        logic [63:0] w;
        logic [30:0] rem;
        logic [30:0] md;
        logic        qneg;
        logic        fail;
        t_side       side;
    } t_div;

    typedef struct packed {
        t_side       side;
        logic [31:0] q;
        logic [23:0] pa;
        logic        fail;
    } t_result;

    localparam int DIV_STAGES = 64;
    localparam logic signed [25:0] TFINE_OFFSET = 26'sd128000;
    localparam logic [20:0] P_BASE = 21'd1048576;
    localparam logic [63:0] DIV_SCALE = 64'd3125;
    localparam logic [63:0] X_BIAS = 64'h0000_8000_0000_0000;

endpackage
`default_nettype wire

// File: hdl/pressure_temperature_compensation.sv
// Top level of the barometric pressure and temperature compensation pipeline.
// Input channel: i_valid/o_ready carry one raw temperature and one raw pressure
// conversion result per beat. Output channel: o_valid/i_ready carry centidegrees,
// fine temperature, pressure in Q24.8, whole pascals and fail per beat.
// The user must write calibration words through i_cfg_we/i_cfg_index/i_cfg_data
// while the pipeline holds no beats (not enforced); they act on every later beat.
// The pipeline has 5 temperature stages, 6 dividend and divisor stages, 64
// divider stages (one quotient bit each) and 7 correction stages. Throughput is
// one beat per cycle while the receiver keeps i_ready high.
// Every stage has its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up while the receiver stalls and new beats
// are taken until the pipeline is full; nothing is lost or repeated.
// Reset clears all valid bits and all calibration registers to zero.
// A zero divisor raises fail and forces both pressure fields to zero.
`default_nettype none
module pressure_temperature_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_temperature_centi,
    output logic signed [23:0] o_fine_temperature,
    output logic signed [31:0] o_pressure_q24_8,
    output logic signed [23:0] o_pressure_pa,
    output logic               o_fail,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    logic [47:0] r_calib_t;
    logic [63:0] r_calib_pa, r_calib_pb;
    logic [15:0] r_calib_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_t  <= '0;
            r_calib_pa <= '0;
            r_calib_pb <= '0;
            r_calib_pc <= '0;
        end else if (i_cfg_we) begin
            unique case (ptc_pkg::t_cfg_index'(i_cfg_index))
                ptc_pkg::CFG_CALIB_T:  r_calib_t  <= i_cfg_data[47:0];
                ptc_pkg::CFG_CALIB_PA: r_calib_pa <= i_cfg_data;
                ptc_pkg::CFG_CALIB_PB: r_calib_pb <= i_cfg_data;
                ptc_pkg::CFG_CALIB_PC: r_calib_pc <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ptc_pkg::t_calib w_calib;

    assign w_calib.t1 = r_calib_t[15:0];
    assign w_calib.t2 = r_calib_t[31:16];
    assign w_calib.t3 = r_calib_t[47:32];
    assign w_calib.p1 = r_calib_pa[15:0];
    assign w_calib.p2 = r_calib_pa[31:16];
    assign w_calib.p3 = r_calib_pa[47:32];
    assign w_calib.p4 = r_calib_pa[63:48];
    assign w_calib.p5 = r_calib_pb[15:0];
    assign w_calib.p6 = r_calib_pb[31:16];
    assign w_calib.p7 = r_calib_pb[47:32];
    assign w_calib.p8 = r_calib_pb[63:48];
    assign w_calib.p9 = r_calib_pc;

    logic               w_t_valid, w_t_ready;
    ptc_pkg::t_tout     w_t_data;
    logic               w_n_valid, w_n_ready;
    ptc_pkg::t_div      w_n_data;
    logic               w_d_valid, w_d_ready;
    ptc_pkg::t_div      w_d_data;
    ptc_pkg::t_result   w_res;

    ptc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_raw_t (i_raw_temperature),
        .i_raw_p (i_raw_pressure),
        .i_calib (w_calib),
        .o_valid (w_t_valid),
        .i_ready (w_t_ready),
        .o_data  (w_t_data)
    );

    ptc_num u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_t_valid),
        .o_ready (w_t_ready),
        .i_data  (w_t_data),
        .i_calib (w_calib),
        .o_valid (w_n_valid),
        .i_ready (w_n_ready),
        .o_data  (w_n_data)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_n_valid),
        .o_ready (w_n_ready),
        .i_data  (w_n_data),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_data  (w_d_data)
    );

    ptc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_data  (w_d_data),
        .i_calib (w_calib),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_res)
    );

    assign o_temperature_centi = w_res.side.tcenti;
    assign o_fine_temperature  = w_res.side.tfine;
    assign o_pressure_q24_8    = w_res.q;
    assign o_pressure_pa       = w_res.pa;
    assign o_fail              = w_res.fail;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fail) |-> (o_pressure_q24_8 == 32'sd0 && o_pressure_pa == 24'sd0))
        else $error("fail beat carries nonzero pressure");

    a_pa_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pressure_q24_8[31]) |-> (o_pressure_pa == o_pressure_q24_8[31:8]))
        else $error("pascal field does not match Q24.8 field");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output beat valid right after reset");
`endif

endmodule
`default_nettype wire

// File: hdl/ptc_temp.sv
// Temperature compensation stages: fine temperature, centidegrees and pressure offset term.
`default_nettype none
module ptc_temp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [19:0]         i_raw_t,
    input  logic [19:0]         i_raw_p,
    input  ptc_pkg::t_calib     i_calib,
    output logic                o_valid,
    input  logic                i_ready,
    output ptc_pkg::t_tout      o_data
);
    localparam int Stages = 5;

    logic [Stages-1:0] r_v, w_rdy, w_in_v, w_en;

    assign w_rdy  = ~r_v | {i_ready, w_rdy[Stages-1:1]};
    assign w_in_v = {r_v[Stages-2:0], i_valid};
    assign w_en   = w_rdy & w_in_v;
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[Stages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~w_rdy) | (w_in_v & w_rdy);
        end
    end

    logic signed [17:0] n_d1, r_d1;
    logic signed [16:0] n_d2, r_d2;
    logic [19:0]        r_adcp1, r_adcp2, r_adcp3, r_adcp4;
    logic signed [33:0] n_m1, n_m2, r_m1, r_m2;
    logic signed [22:0] n_tv1, r_tv1;
    logic signed [21:0] n_sq;
    logic signed [37:0] n_m3, r_m3;
    logic signed [24:0] n_tf, r_tf;
    logic signed [28:0] n_t5;
    logic signed [25:0] n_a;
    ptc_pkg::t_tout     r_out;

    always_comb begin
        n_d1  = $signed({1'b0, i_raw_t[19:3]}) - $signed({1'b0, i_calib.t1, 1'b0});
        n_d2  = $signed({1'b0, i_raw_t[19:4]}) - $signed({1'b0, i_calib.t1});
        n_m1  = r_d1 * $signed(i_calib.t2);
        n_m2  = r_d2 * r_d2;
        n_tv1 = r_m1[33:11];
        n_sq  = r_m2[33:12];
        n_m3  = n_sq * $signed(i_calib.t3);
        n_tf  = {{2{r_tv1[22]}}, r_tv1} + {r_m3[37], r_m3[37:14]};
        n_t5  = r_tf * 29'sd5 + 29'sd128;
        n_a   = r_tf - ptc_pkg::TFINE_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_d1    <= n_d1;
            r_d2    <= n_d2;
            r_adcp1 <= i_raw_p;
        end
        if (w_en[1]) begin
            r_m1    <= n_m1;
            r_m2    <= n_m2;
            r_adcp2 <= r_adcp1;
        end
        if (w_en[2]) begin
            r_tv1   <= n_tv1;
            r_m3    <= n_m3;
            r_adcp3 <= r_adcp2;
        end
        if (w_en[3]) begin
            r_tf    <= n_tf;
            r_adcp4 <= r_adcp3;
        end
        if (w_en[4]) begin
            r_out.side.tcenti <= {{3{n_t5[28]}}, n_t5[28:8]};
            r_out.side.tfine  <= r_tf[23:0];
            r_out.a           <= n_a;
            r_out.adcp        <= r_adcp4;
        end
    end

    assign o_data = r_out;

endmodule
`default_nettype wire

// File: hdl/ptc_num.sv
// Pressure dividend and divisor stages, ending in sign and magnitude for the divider.
`default_nettype none
module ptc_num (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ptc_pkg::t_tout      i_data,
    input  ptc_pkg::t_calib     i_calib,
    output logic                o_valid,
    input  logic                i_ready,
    output ptc_pkg::t_div       o_data
);
    localparam int Stages = 6;

    logic [Stages-1:0] r_v, w_rdy, w_in_v, w_en;

    assign w_rdy  = ~r_v | {i_ready, w_rdy[Stages-1:1]};
    assign w_in_v = {r_v[Stages-2:0], i_valid};
    assign w_en   = w_rdy & w_in_v;
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[Stages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~w_rdy) | (w_in_v & w_rdy);
        end
    end

    ptc_pkg::t_side r_side [Stages-1];
    ptc_pkg::t_side w_side_in [Stages-1];

    assign w_side_in[0] = i_data.side;
    for (genvar k = 1; k < Stages - 1; k++) begin : g_side
        assign w_side_in[k] = r_side[k-1];
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Stages - 1; k++) begin
            if (w_en[k]) begin
                r_side[k] <= w_side_in[k];
            end
        end
    end

    logic signed [25:0] n_a;
    logic signed [51:0] n_aa, r_aa;
    logic signed [41:0] n_ap5, n_ap2, r_ap5, r_ap2, r_ap5_2, r_ap2_2;
    logic [19:0]        r_adcp1, r_adcp2, r_adcp3;
    logic signed [63:0] n_b1, n_a1, r_b1, r_a1, n_a1s;
    logic [63:0]        n_b, n_x, r_b, r_x;
    logic [47:0]        n_pl, r_pl;
    logic [31:0]        n_ph, r_ph;
    logic [20:0]        n_pdiff;
    logic [63:0]        n_num0, r_num0;
    logic [63:0]        n_prod, n_num, r_num;
    logic [30:0]        r_den;
    ptc_pkg::t_div      r_out;

    always_comb begin
        n_a     = $signed(i_data.a);
        n_aa    = n_a * n_a;
        n_ap5   = n_a * $signed(i_calib.p5);
        n_ap2   = n_a * $signed(i_calib.p2);
        n_b1    = r_aa * $signed(i_calib.p6);
        n_a1    = r_aa * $signed(i_calib.p3);
        n_a1s   = r_a1 >>> 8;
        n_b     = r_b1 + ({{22{r_ap5_2[41]}}, r_ap5_2} << 17)
                + ({{48{i_calib.p4[15]}}, i_calib.p4} << 35);
        n_x     = ptc_pkg::X_BIAS + n_a1s + ({{22{r_ap2_2[41]}}, r_ap2_2} << 12);
        n_pl    = r_x[31:0] * i_calib.p1;
        n_ph    = r_x[63:32] * {16'd0, i_calib.p1};
        n_pdiff = ptc_pkg::P_BASE - {1'b0, r_adcp3};
        n_num0  = {12'd0, n_pdiff, 31'd0} - r_b;
        n_prod  = {16'd0, r_pl} + {r_ph, 32'd0};
        n_num   = r_num0 * ptc_pkg::DIV_SCALE;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_aa    <= n_aa;
            r_ap5   <= n_ap5;
            r_ap2   <= n_ap2;
            r_adcp1 <= i_data.adcp;
        end
        if (w_en[1]) begin
            r_b1    <= n_b1;
            r_a1    <= n_a1;
            r_ap5_2 <= r_ap5;
            r_ap2_2 <= r_ap2;
            r_adcp2 <= r_adcp1;
        end
        if (w_en[2]) begin
            r_b     <= n_b;
            r_x     <= n_x;
            r_adcp3 <= r_adcp2;
        end
        if (w_en[3]) begin
            r_pl    <= n_pl;
            r_ph    <= n_ph;
            r_num0  <= n_num0;
        end
        if (w_en[4]) begin
            r_den   <= n_prod[63:33];
            r_num   <= n_num;
        end
        if (w_en[5]) begin
            r_out.w    <= r_num[63] ? (64'd0 - r_num) : r_num;
            r_out.rem  <= '0;
            r_out.md   <= r_den[30] ? (31'd0 - r_den) : r_den;
            r_out.qneg <= r_num[63] ^ r_den[30];
            r_out.fail <= (r_den == 31'd0);
            r_out.side <= r_side[Stages-2];
        end
    end

    assign o_data = r_out;

endmodule
`default_nettype wire

// File: hdl/ptc_div.sv
// Restoring divider: one quotient bit per pipeline stage over the 64-bit dividend magnitude.
`default_nettype none
module ptc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ptc_pkg::t_div       i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output ptc_pkg::t_div       o_data
);
    localparam int Stages = ptc_pkg::DIV_STAGES;

    logic [Stages-1:0] r_v, w_rdy, w_in_v, w_en;

    assign w_rdy  = ~r_v | {i_ready, w_rdy[Stages-1:1]};
    assign w_in_v = {r_v[Stages-2:0], i_valid};
    assign w_en   = w_rdy & w_in_v;
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[Stages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~w_rdy) | (w_in_v & w_rdy);
        end
    end

    ptc_pkg::t_div r_st [Stages];
    ptc_pkg::t_div w_st_in [Stages];

    assign w_st_in[0] = i_data;

    for (genvar k = 0; k < Stages; k++) begin : g_stage
        logic [31:0] trial;
        logic [32:0] diff;
        logic        ge;
        ptc_pkg::t_div n_st;

        if (k > 0) begin : g_link
            assign w_st_in[k] = r_st[k-1];
        end

        // Shift the next dividend bit into the partial remainder and try the subtract.
        always_comb begin
            trial = {w_st_in[k].rem, w_st_in[k].w[63]};
            diff  = {1'b0, trial} - {2'b00, w_st_in[k].md};
            ge    = !diff[32];
            n_st      = w_st_in[k];
            n_st.rem  = ge ? diff[30:0] : trial[30:0];
            n_st.w    = {w_st_in[k].w[62:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_data = r_st[Stages-1];

endmodule
`default_nettype wire

// File: hdl/ptc_post.sv
// Post-division stages: sign restore, P7 to P9 correction terms and pascal rounding.
`default_nettype none
module ptc_post (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ptc_pkg::t_div       i_data,
    input  ptc_pkg::t_calib     i_calib,
    output logic                o_valid,
    input  logic                i_ready,
    output ptc_pkg::t_result    o_data
);
    localparam int Stages = 7;

    typedef struct packed {
        ptc_pkg::t_side side;
        logic           fail;
    } t_carry;

    logic [Stages-1:0] r_v, w_rdy, w_in_v, w_en;

    assign w_rdy  = ~r_v | {i_ready, w_rdy[Stages-1:1]};
    assign w_in_v = {r_v[Stages-2:0], i_valid};
    assign w_en   = w_rdy & w_in_v;
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[Stages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~w_rdy) | (w_in_v & w_rdy);
        end
    end

    t_carry r_cy [Stages-1];
    t_carry w_cy_in [Stages-1];

    assign w_cy_in[0] = '{side: i_data.side, fail: i_data.fail};
    for (genvar k = 1; k < Stages - 1; k++) begin : g_carry
        assign w_cy_in[k] = r_cy[k-1];
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Stages - 1; k++) begin
            if (w_en[k]) begin
                r_cy[k] <= w_cy_in[k];
            end
        end
    end

    logic [63:0]        n_p, r_p1, r_p2, r_p3;
    logic signed [63:0] n_s;
    logic [63:0]        n_pp0, r_pp0;
    logic [31:0]        n_pp1, r_pp1;
    logic signed [48:0] n_c2l, r_c2l, n_c1l, r_c1l;
    logic [31:0]        n_c2h, r_c2h, n_c1h, r_c1h;
    logic [63:0]        n_ss, r_ss, n_c2f, n_c1f;
    logic signed [63:0] n_c2, r_c2, n_c1, r_c1, n_sh;
    logic [63:0]        n_pc2, r_pc2, r_pc2_5, n_sum, n_q64;
    logic [31:0]        r_q, n_mag;
    logic [23:0]        n_r, n_pa;
    ptc_pkg::t_result   r_out;

    always_comb begin
        n_p   = i_data.qneg ? (64'd0 - i_data.w) : i_data.w;
        n_s   = $signed(r_p1) >>> 13;
        // Low 64 bits of the square from two 32-bit partial products, the cross term doubled.
        n_pp0 = n_s[31:0] * n_s[31:0];
        n_pp1 = n_s[31:0] * n_s[63:32];
        n_c2l = $signed({1'b0, r_p1[31:0]}) * $signed(i_calib.p8);
        n_c2h = r_p1[63:32] * {{16{i_calib.p8[15]}}, i_calib.p8};
        n_ss  = r_pp0 + {r_pp1[30:0], 33'd0};
        n_c2f = {{15{r_c2l[48]}}, r_c2l} + {r_c2h, 32'd0};
        n_c2  = $signed(n_c2f) >>> 19;
        n_c1l = $signed({1'b0, r_ss[31:0]}) * $signed(i_calib.p9);
        n_c1h = r_ss[63:32] * {{16{i_calib.p9[15]}}, i_calib.p9};
        n_pc2 = r_p3 + r_c2;
        n_c1f = {{15{r_c1l[48]}}, r_c1l} + {r_c1h, 32'd0};
        n_c1  = $signed(n_c1f) >>> 25;
        n_sum = r_pc2_5 + r_c1;
        n_sh  = $signed(n_sum) >>> 8;
        n_q64 = n_sh + {{44{i_calib.p7[15]}}, i_calib.p7, 4'd0};
        // Whole pascals truncate toward zero, so shift the magnitude.
        n_mag = r_q[31] ? (32'd0 - r_q) : r_q;
        n_r   = n_mag[31:8];
        n_pa  = r_q[31] ? (24'd0 - n_r) : n_r;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_p1 <= n_p;
        end
        if (w_en[1]) begin
            r_pp0 <= n_pp0;
            r_pp1 <= n_pp1;
            r_c2l <= n_c2l;
            r_c2h <= n_c2h;
            r_p2  <= r_p1;
        end
        if (w_en[2]) begin
            r_ss <= n_ss;
            r_c2 <= n_c2;
            r_p3 <= r_p2;
        end
        if (w_en[3]) begin
            r_c1l <= n_c1l;
            r_c1h <= n_c1h;
            r_pc2 <= n_pc2;
        end
        if (w_en[4]) begin
            r_c1    <= n_c1;
            r_pc2_5 <= r_pc2;
        end
        if (w_en[5]) begin
            r_q <= n_q64[31:0];
        end
        if (w_en[6]) begin
            r_out.side <= r_cy[Stages-2].side;
            r_out.fail <= r_cy[Stages-2].fail;
            r_out.q    <= r_cy[Stages-2].fail ? 32'd0 : r_q;
            r_out.pa   <= r_cy[Stages-2].fail ? 24'd0 : n_pa;
        end
    end

    assign o_data = r_out;

endmodule
`default_nettype wire
